// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define SPQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
// package for the sorted priority queue: widths, codes and shared types
`default_nettype none

package spq_pkg;

  localparam int DefCapacity = 16;
  localparam int DataW       = 32;
  localparam int StatusW     = 2;
  localparam int FillW       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } spq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic               load_item;
    logic               rd_prev;
    logic               rd_head;
    logic               wr_shift;
    logic               wr_new;
    logic               step_back;
    logic               push;
    logic               pop;
    logic               res_load;
    logic [StatusW-1:0] res_status;
    logic               res_take_rdata;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic prev_greater;
    logic slot_one;
  } spq_sts_t;

endpackage

`default_nettype wire

// ----- src/spq_channels.sv -----
// valid/ready channel interfaces for operations and results
`default_nettype none

interface spq_in_if
  import spq_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [DataW-1:0] item_value;
  logic signed [DataW-1:0] item_priority;

  modport source (output valid, output op, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input op, input item_value, input item_priority,
                  output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] out_value;
  logic signed [DataW-1:0] out_priority;
  logic [FillW-1:0]        fill_level;

  modport source (output valid, output status, output out_value, output out_priority,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input out_value, input out_priority,
                  input fill_level, output ready);
endinterface

`default_nettype wire

// ----- src/spq_datapath.sv -----
// entry memory kept as a circular buffer, pointers, count and result register
`default_nettype none

`include "assert_macros.svh"

module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire spq_cmd_t                cmd,
  output spq_sts_t                     sts,
  input  wire logic signed [DataW-1:0] in_value,
  input  wire logic signed [DataW-1:0] in_prio,
  output logic [StatusW-1:0]           res_status,
  output logic signed [DataW-1:0]      res_value,
  output logic signed [DataW-1:0]      res_prio,
  output logic [FillW-1:0]             res_fill
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LastIdx  = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  spq_entry_t mem [CAPACITY];

  logic [IW-1:0]           head_r, head_nxt;
  logic [IW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]           slot_r, slot_nxt;
  logic signed [DataW-1:0] item_value_r, item_prio_r;
  spq_entry_t              rdata_r;
  logic [IW-1:0]           rd_addr;
  spq_entry_t              wr_data;
  logic                    wr_en, rd_en;
  logic [31:0]             fill_wide;

  function automatic logic [IW-1:0] ptr_next(input logic [IW-1:0] p);
    ptr_next = (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ptr_prev(input logic [IW-1:0] p);
    ptr_prev = (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  always_comb begin
    head_nxt   = cmd.pop ? ptr_next(head_r) : head_r;
    tail_nxt   = cmd.push ? ptr_next(tail_r) : tail_r;
    count_nxt  = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
    wr_ptr_nxt = wr_ptr_r;
    slot_nxt   = slot_r;
    if (cmd.load_item) begin
      wr_ptr_nxt = tail_r;
      slot_nxt   = count_r;
    end else if (cmd.step_back) begin
      wr_ptr_nxt = ptr_prev(wr_ptr_r);
      slot_nxt   = slot_r - 1'b1;
    end
    rd_en     = cmd.rd_head | cmd.rd_prev;
    rd_addr   = cmd.rd_head ? head_r : ptr_prev(wr_ptr_r);
    wr_en     = cmd.wr_shift | cmd.wr_new;
    wr_data   = cmd.wr_shift ? rdata_r
                             : spq_entry_t'{value: item_value_r, prio: item_prio_r};
    fill_wide = 32'(count_nxt);
  end

  assign sts = spq_sts_t'{
    empty:        (count_r == '0),
    full:         (count_r == CapCount),
    prev_greater: (rdata_r.prio > item_prio_r),
    slot_one:     (slot_r == CW'(1))
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_ptr_r <= wr_ptr_nxt;
    slot_r   <= slot_nxt;
    if (cmd.load_item) begin
      item_value_r <= in_value;
      item_prio_r  <= in_prio;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_value  <= cmd.res_take_rdata ? rdata_r.value : '0;
      res_prio   <= cmd.res_take_rdata ? rdata_r.prio : '0;
      res_fill   <= fill_wide[FillW-1:0];
    end
  end

  // entry storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  `SPQ_ASSERT(a_count_bound, count_r <= CapCount, "entry count above capacity")
  `SPQ_NEVER(a_push_full, cmd.push && sts.full, "push into a full queue")
  `SPQ_ASSERT(a_ptr_match, (count_r == '0 || count_r == CapCount) |-> head_r == tail_r,
    "head and tail disagree with count")

endmodule

`default_nettype wire

// ----- src/spq_controller.sv -----
// controller state machine: handshakes, insert scan and delete sequencing
`default_nettype none

`include "assert_macros.svh"

module spq_controller
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire spq_sts_t sts,
  output spq_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_DEL_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r;
        if (in_valid && !out_valid_r) begin
          cmd.load_item = 1'b1;
          if (in_op == OP_INSERT) begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STATUS_FULL;
            end else if (sts.empty) begin
              state_nxt = S_INS_PUT;
            end else begin
              state_nxt = S_INS_RD;
            end
          end else begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STATUS_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_DEL_OUT;
            end
          end
        end
      end
      S_INS_RD: begin
        cmd.rd_prev = 1'b1;
        state_nxt   = S_INS_CMP;
      end
      S_INS_CMP: begin
        // move the older entry up one slot while it is less urgent
        if (sts.prev_greater) begin
          cmd.wr_shift  = 1'b1;
          cmd.step_back = 1'b1;
          state_nxt     = sts.slot_one ? S_INS_PUT : S_INS_RD;
        end else begin
          cmd.wr_new     = 1'b1;
          cmd.push       = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = STATUS_DONE;
          state_nxt      = S_IDLE;
        end
      end
      S_INS_PUT: begin
        cmd.wr_new     = 1'b1;
        cmd.push       = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = STATUS_DONE;
        state_nxt      = S_IDLE;
      end
      S_DEL_OUT: begin
        cmd.pop            = 1'b1;
        cmd.res_load       = 1'b1;
        cmd.res_status     = STATUS_DONE;
        cmd.res_take_rdata = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SPQ_NEVER(a_res_overwrite, cmd.res_load && out_valid_r, "result overwritten before taken")
  `SPQ_ASSERT(a_cmp_after_rd, state_r == S_INS_CMP |-> $past(state_r) == S_INS_RD,
    "compare without a preceding read")
  `SPQ_NEVER(a_del_empty, state_r == S_DEL_OUT && sts.empty, "delete sequence on empty queue")

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// Sorted priority queue, lowest priority number first, ties leave in arrival order.
// Entries live in a single-port-write, registered-read memory used as a circular
// buffer, so a delete reads the head, then pops it.
// An insert walks back from the tail through that memory, one entry at a time (read,
// then compare and move up); the last read and compare finds its place, unless the
// new entry lands at the head (an empty queue included). A refused insert or a
// delete on an empty queue answers straight from the idle state. One transaction
// is in flight at a time and the next is accepted once the result register has
// been taken. No clearing pass is needed.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  spq_cmd_t cmd;
  spq_sts_t sts;
  logic     ctl_in_ready;
  logic     ctl_out_valid;

  spq_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (ctl_in_ready),
    .out_valid (ctl_out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_ch.item_value),
    .in_prio    (in_ch.item_priority),
    .res_status (out_ch.status),
    .res_value  (out_ch.out_value),
    .res_prio   (out_ch.out_priority),
    .res_fill   (out_ch.fill_level)
  );

  assign in_ch.ready  = ctl_in_ready;
  assign out_ch.valid = ctl_out_valid;

endmodule

`default_nettype wire
